FILE: rtl/rgb_to_hsv_pixel_convert_core_assert.svh
// Assertion macros for the RGB to HSV converter checker.
`ifndef RGB_TO_HSV_PIXEL_CONVERT_CORE_ASSERT_SVH
`define RGB_TO_HSV_PIXEL_CONVERT_CORE_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define RHC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds a fixed number of cycles after ante.
`define RHC_ASSERT_DELAY(label, clk, rst, ante, dly, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
      else $error(msg);

`endif

FILE: rtl/rhc_pkg.sv
// Shared widths, constants and pipeline types of the RGB to HSV converter.
package rhc_pkg;

   localparam int PIX_W              = 8;
   localparam int HUE_W              = 9;
   localparam int SAT_Q_W            = 8;
   localparam int HUE_Q_W            = 7;
   localparam int SAT_NUM_W          = 2 * PIX_W;
   localparam int HUE_NUM_W          = 15;
   localparam int DIV_BITS_PER_STAGE = 2;
   localparam int DIV_STAGES         = SAT_Q_W / DIV_BITS_PER_STAGE;

   localparam int FULL_SCALE  = 255;
   localparam int FRAC_SCALE  = 100;
   localparam int SECTOR_DEG  = 60;
   localparam int TURN_DEG    = 360;
   localparam int OFS_RED     = 36000;
   localparam int OFS_GREEN   = 12000;
   localparam int OFS_BLUE    = 24000;

   localparam int OFS_RED_DEG   = OFS_RED / FRAC_SCALE;
   localparam int OFS_GREEN_DEG = OFS_GREEN / FRAC_SCALE;
   localparam int OFS_BLUE_DEG  = OFS_BLUE / FRAC_SCALE;

   // 60/100 reduces to 3/5
   localparam int Q_MUL = SECTOR_DEG / 20;
   localparam int Q_DEN = FRAC_SCALE / 20;

   // x/5 == (x*205) >> 10 for every x below 1024
   localparam int DIV5_MUL   = 205;
   localparam int DIV5_SHIFT = 10;
   localparam int SCALED_W   = 9;
   localparam int DEG_PROD_W = 16;

   typedef enum logic [1:0] {
      SECTOR_RED,
      SECTOR_GREEN,
      SECTOR_BLUE
   } sector_type;

   typedef struct packed {
      logic                 valid;
      sector_type           sector;
      logic                 neg;
      logic                 gray;
      logic                 black;
      logic [PIX_W-1:0]     val;
      logic [PIX_W-1:0]     delta;
      logic [SAT_NUM_W-1:0] sat_rem;
      logic [SAT_Q_W-1:0]   sat_q;
      logic [HUE_NUM_W-1:0] hue_rem;
      logic [HUE_Q_W-1:0]   hue_q;
   } pipe_type;

endpackage

FILE: rtl/rgb_to_hsv_pixel_convert_core.sv
// Top level of the pipelined RGB to HSV pixel converter.
//
// Usage:
//   Input channel: drive req_red, req_green, req_blue and raise start. A beat
//   is taken at every rising edge with start high and busy low. busy is low
//   whenever reset is low, so one pixel can enter in every cycle.
//   Result channel: rsp_valid is high for exactly one cycle per pixel, with
//   rsp_hue_deg (0..359), rsp_sat_level and rsp_val_level valid in that
//   cycle. The receiver cannot hold results off; results leave in order.
//   Throughput: one pixel per cycle outside of reset. Stages: input
//   register, min/max and operand prep, four divider stages (two
//   saturation quotient bits each; the hue divider takes one bit in the
//   first and two in each of the others), then hue scaling and the output
//   register. The divider chain sets the depth.
//   Reset: synchronous, active high. Clears every stage valid bit, so
//   pixels in flight are dropped; busy is high while reset is held.
module rgb_to_hsv_pixel_convert_core
   import rhc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [PIX_W-1:0] req_red,
   input  logic [PIX_W-1:0] req_green,
   input  logic [PIX_W-1:0] req_blue,
   output logic             rsp_valid,
   output logic [HUE_W-1:0] rsp_hue_deg,
   output logic [PIX_W-1:0] rsp_sat_level,
   output logic [PIX_W-1:0] rsp_val_level
);

   logic     accept;
   pipe_type div_pipe [DIV_STAGES+1];

   // Take a beat every cycle outside of reset
   assign busy   = reset;
   assign accept = start & ~busy;

   // Register the pixel, find max/min, pick the sector, form both dividends
   rhc_prep u_prep (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .red      (req_red),
      .green    (req_green),
      .blue     (req_blue),
      .prep_out (div_pipe[0])
   );

   // Advance both restoring dividers, most significant quotient bits first
   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
      rhc_div_stage #(
         .BIT_HI (SAT_Q_W - 1 - k * DIV_BITS_PER_STAGE)
      ) u_div_stage (
         .clock     (clock),
         .reset     (reset),
         .stage_in  (div_pipe[k]),
         .stage_out (div_pipe[k+1])
      );
   end

   // Scale to degrees, add the sector offset, wrap, and register the result
   rhc_hue_final u_hue_final (
      .clock         (clock),
      .reset         (reset),
      .fin_in        (div_pipe[DIV_STAGES]),
      .rsp_valid     (rsp_valid),
      .rsp_hue_deg   (rsp_hue_deg),
      .rsp_sat_level (rsp_sat_level),
      .rsp_val_level (rsp_val_level)
   );

endmodule

FILE: rtl/rhc_prep.sv
// Input register and first stage: max, min, sector and divider operands.
module rhc_prep
   import rhc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [PIX_W-1:0] red,
   input  logic [PIX_W-1:0] green,
   input  logic [PIX_W-1:0] blue,
   output pipe_type         prep_out
);

   logic             pix_valid_ff;
   logic [PIX_W-1:0] red_ff;
   logic [PIX_W-1:0] green_ff;
   logic [PIX_W-1:0] blue_ff;

   logic             prep_valid_ff;
   pipe_type         prep_data_ff;
   pipe_type         prep_data_in;

   logic [PIX_W-1:0]        mx;
   logic [PIX_W-1:0]        mn;
   logic [PIX_W-1:0]        delta;
   logic signed [PIX_W:0]   diff;
   logic [PIX_W-1:0]        diff_mag;
   sector_type              sector;

   always_ff @(posedge clock) begin
      red_ff   <= red;
      green_ff <= green;
      blue_ff  <= blue;
      if (reset) begin
         pix_valid_ff <= 1'b0;
      end else begin
         pix_valid_ff <= accept;
      end
   end

   always_comb begin
      mx = (red_ff > green_ff) ? ((red_ff > blue_ff) ? red_ff : blue_ff)
                               : ((green_ff > blue_ff) ? green_ff : blue_ff);
      mn = (red_ff < green_ff) ? ((red_ff < blue_ff) ? red_ff : blue_ff)
                               : ((green_ff < blue_ff) ? green_ff : blue_ff);
      delta = mx - mn;

      // red wins ties, then green
      if (red_ff == mx) begin
         sector = SECTOR_RED;
         diff   = $signed({1'b0, green_ff}) - $signed({1'b0, blue_ff});
      end else if (green_ff == mx) begin
         sector = SECTOR_GREEN;
         diff   = $signed({1'b0, blue_ff}) - $signed({1'b0, red_ff});
      end else begin
         sector = SECTOR_BLUE;
         diff   = $signed({1'b0, red_ff}) - $signed({1'b0, green_ff});
      end
      diff_mag = diff[PIX_W] ? PIX_W'(-diff) : diff[PIX_W-1:0];

      prep_data_in.valid   = pix_valid_ff;
      prep_data_in.sector  = sector;
      prep_data_in.neg     = diff[PIX_W];
      prep_data_in.gray    = (delta == '0);
      prep_data_in.black   = (mx == '0);
      prep_data_in.val     = mx;
      prep_data_in.delta   = delta;
      prep_data_in.sat_rem = SAT_NUM_W'(delta) * SAT_NUM_W'(FULL_SCALE);
      prep_data_in.sat_q   = '0;
      prep_data_in.hue_rem = HUE_NUM_W'(diff_mag) * HUE_NUM_W'(FRAC_SCALE);
      prep_data_in.hue_q   = '0;
   end

   always_ff @(posedge clock) begin
      prep_data_ff <= prep_data_in;
      if (reset) begin
         prep_valid_ff <= 1'b0;
      end else begin
         prep_valid_ff <= prep_data_in.valid;
      end
   end

   always_comb begin
      prep_out       = prep_data_ff;
      prep_out.valid = prep_valid_ff;
   end

endmodule

FILE: rtl/rhc_div_stage.sv
// One registered stage of the two restoring dividers, two saturation and up to two hue quotient bits per stage.
module rhc_div_stage
   import rhc_pkg::*;
#(
   parameter int BIT_HI = SAT_Q_W - 1
)
(
   input  logic     clock,
   input  logic     reset,
   input  pipe_type stage_in,
   output pipe_type stage_out
);

   localparam int SAT_POS_W = $clog2(SAT_Q_W);
   localparam int HUE_POS_W = $clog2(HUE_Q_W);

   logic     stage_valid_ff;
   pipe_type stage_data_ff;
   pipe_type stage_data_in;

   always_comb begin
      logic [SAT_POS_W-1:0] sat_pos;
      logic [HUE_POS_W-1:0] hue_pos;
      logic [SAT_NUM_W-1:0] sat_trial;
      logic [HUE_NUM_W-1:0] hue_trial;

      stage_data_in = stage_in;
      sat_pos       = '0;
      hue_pos       = '0;
      sat_trial     = '0;
      hue_trial     = '0;
      for (int j = 0; j < DIV_BITS_PER_STAGE; j++) begin
         // saturation: delta*255 / max
         sat_pos   = SAT_POS_W'(BIT_HI - j);
         sat_trial = SAT_NUM_W'(stage_data_in.val) << sat_pos;
         if (stage_data_in.sat_rem >= sat_trial) begin
            stage_data_in.sat_rem        = stage_data_in.sat_rem - sat_trial;
            stage_data_in.sat_q[sat_pos] = 1'b1;
         end
         // hue fraction: |diff|*100 / delta, at most 100
         if (BIT_HI - j < HUE_Q_W) begin
            hue_pos   = HUE_POS_W'(BIT_HI - j);
            hue_trial = HUE_NUM_W'(stage_data_in.delta) << hue_pos;
            if (stage_data_in.hue_rem >= hue_trial) begin
               stage_data_in.hue_rem        = stage_data_in.hue_rem - hue_trial;
               stage_data_in.hue_q[hue_pos] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      stage_data_ff <= stage_data_in;
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_data_in.valid;
      end
   end

   always_comb begin
      stage_out       = stage_data_ff;
      stage_out.valid = stage_valid_ff;
   end

endmodule

FILE: rtl/rhc_hue_final.sv
// Last stage: degree scaling, sector offset, wrap and the result register.
module rhc_hue_final
   import rhc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  pipe_type         fin_in,
   output logic             rsp_valid,
   output logic [HUE_W-1:0] rsp_hue_deg,
   output logic [PIX_W-1:0] rsp_sat_level,
   output logic [PIX_W-1:0] rsp_val_level
);

   logic [SCALED_W-1:0]   scaled;
   logic [DEG_PROD_W-1:0] prod;
   logic [HUE_W-1:0]      step_deg;
   logic [HUE_W-1:0]      base_deg;
   logic [HUE_W-1:0]      raw_deg;
   logic [HUE_W-1:0]      hue_in;
   logic [PIX_W-1:0]      sat_in;

   logic                  rsp_valid_ff;
   logic [HUE_W-1:0]      hue_ff;
   logic [PIX_W-1:0]      sat_ff;
   logic [PIX_W-1:0]      val_ff;

   always_comb begin
      // floor(3q/5) for the signed quotient: round the magnitude up when negative
      scaled   = SCALED_W'(fin_in.hue_q) * SCALED_W'(Q_MUL)
               + (fin_in.neg ? SCALED_W'(Q_DEN - 1) : SCALED_W'(0));
      prod     = DEG_PROD_W'(scaled) * DEG_PROD_W'(DIV5_MUL);
      step_deg = HUE_W'(prod[DEG_PROD_W-1:DIV5_SHIFT]);

      case (fin_in.sector)
         SECTOR_RED:   base_deg = HUE_W'(OFS_RED_DEG);
         SECTOR_GREEN: base_deg = HUE_W'(OFS_GREEN_DEG);
         SECTOR_BLUE:  base_deg = HUE_W'(OFS_BLUE_DEG);
         default:      base_deg = '0;
      endcase

      raw_deg = fin_in.neg ? (base_deg - step_deg) : (base_deg + step_deg);
      if (raw_deg >= HUE_W'(TURN_DEG)) begin
         hue_in = raw_deg - HUE_W'(TURN_DEG);
      end else begin
         hue_in = raw_deg;
      end
      if (fin_in.gray) begin
         hue_in = '0;
      end
      sat_in = fin_in.black ? '0 : fin_in.sat_q;
   end

   always_ff @(posedge clock) begin
      hue_ff <= hue_in;
      sat_ff <= sat_in;
      val_ff <= fin_in.val;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= fin_in.valid;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hue_deg   = hue_ff;
   assign rsp_sat_level = sat_ff;
   assign rsp_val_level = val_ff;

endmodule

FILE: rtl/rhc_checker.sv
// Port-level checker for the RGB to HSV converter, bound to the top level.
`include "rgb_to_hsv_pixel_convert_core_assert.svh"

module rhc_checker
   import rhc_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic [PIX_W-1:0] req_red,
   input logic [PIX_W-1:0] req_green,
   input logic [PIX_W-1:0] req_blue,
   input logic             rsp_valid,
   input logic [HUE_W-1:0] rsp_hue_deg,
   input logic [PIX_W-1:0] rsp_sat_level,
   input logic [PIX_W-1:0] rsp_val_level
);

   `RHC_ASSERT_IMPL(a_rsp_has_beat, clock, reset, rsp_valid, $past(start && !busy, 7), "result without an input beat seven cycles back")
   `RHC_ASSERT_IMPL(a_hue_range, clock, reset, rsp_valid, rsp_hue_deg < HUE_W'(TURN_DEG), "hue out of range")
   `RHC_ASSERT_IMPL(a_black_zero, clock, reset, rsp_valid && rsp_val_level == '0, rsp_sat_level == '0 && rsp_hue_deg == '0, "black pixel with nonzero hue or saturation")
   `RHC_ASSERT_DELAY(a_gray_pixel, clock, reset, start && !busy && req_red == req_green && req_green == req_blue, 7, rsp_valid && rsp_hue_deg == '0 && rsp_sat_level == '0 && rsp_val_level == $past(req_red, 7), "gray pixel gave wrong result")

endmodule

bind rgb_to_hsv_pixel_convert_core rhc_checker u_rhc_checker (.*);

FILE: verif/tb_rgb_to_hsv_pixel_convert_core.sv
// Self-checking testbench of the pipelined RGB to HSV pixel converter.
`timescale 1ns / 100ps

module tb_rgb_to_hsv_pixel_convert_core;
   import rhc_pkg::*;

   // Cycles without any accepted beat or result beat before the run is declared hung.
   localparam int STALL_LIMIT   = 1000;
   // Pipeline depth plus margin for the drain.
   localparam int DRAIN_CYCLES  = 7 + 13;
   localparam int RANDOM_PIXELS = 170;

   // Expected HSV triple for one accepted pixel, plus the pixel for reporting.
   typedef struct {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
      logic [HUE_W-1:0] hue_deg;
      logic [PIX_W-1:0] sat_level;
      logic [PIX_W-1:0] val_level;
   } hsv_triple_type;

   // Holds the expected HSV triples in issue order and checks results.
   class hsv_scoreboard_type;
      hsv_triple_type pending_hsv[$];
      int             mismatches = 0;

      // Predict the HSV triple of an accepted pixel and queue it.
      function void note_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                               logic [PIX_W-1:0] b);
         hsv_triple_type exp_hsv;
         sector_type     sector;
         int             mx, mn, delta, diff, quot, deg_sum, ofs, hue;
         mx    = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
         mn    = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
         delta = mx - mn;
         hue   = 0;
         if (delta != 0) begin
            // Ties resolve to red first, then green.
            if (mx == r)      sector = SECTOR_RED;
            else if (mx == g) sector = SECTOR_GREEN;
            else              sector = SECTOR_BLUE;
            case (sector)
               SECTOR_RED: begin
                  diff = int'(g) - int'(b);
                  ofs  = OFS_RED;
               end
               SECTOR_GREEN: begin
                  diff = int'(b) - int'(r);
                  ofs  = OFS_GREEN;
               end
               default: begin
                  diff = int'(r) - int'(g);
                  ofs  = OFS_BLUE;
               end
            endcase
            // Signed int division truncates toward zero.
            quot    = (diff * FRAC_SCALE) / delta;
            deg_sum = SECTOR_DEG * quot + ofs;
            hue     = deg_sum / FRAC_SCALE;
            if (hue >= TURN_DEG) hue -= TURN_DEG;
         end
         exp_hsv.red       = r;
         exp_hsv.green     = g;
         exp_hsv.blue      = b;
         exp_hsv.hue_deg   = HUE_W'(hue);
         exp_hsv.sat_level = (mx == 0) ? '0 : PIX_W'((delta * FULL_SCALE) / mx);
         exp_hsv.val_level = PIX_W'(mx);
         pending_hsv.push_back(exp_hsv);
      endfunction

      // Compare one result beat against the oldest expected triple.
      function void check_result(logic [HUE_W-1:0] hue_deg,
                                 logic [PIX_W-1:0] sat_level,
                                 logic [PIX_W-1:0] val_level);
         hsv_triple_type exp_hsv;
         if (pending_hsv.size() == 0) begin
            $error("unexpected result beat: hue_deg=%0d sat_level=%0d val_level=%0d",
                   hue_deg, sat_level, val_level);
            mismatches++;
            return;
         end
         exp_hsv = pending_hsv.pop_front();
         if (hue_deg !== exp_hsv.hue_deg) begin
            $error("hue_deg mismatch for rgb(%0d,%0d,%0d): expected %0d, actual %0d",
                   exp_hsv.red, exp_hsv.green, exp_hsv.blue, exp_hsv.hue_deg, hue_deg);
            mismatches++;
         end
         if (sat_level !== exp_hsv.sat_level) begin
            $error("sat_level mismatch for rgb(%0d,%0d,%0d): expected %0d, actual %0d",
                   exp_hsv.red, exp_hsv.green, exp_hsv.blue, exp_hsv.sat_level,
                   sat_level);
            mismatches++;
         end
         if (val_level !== exp_hsv.val_level) begin
            $error("val_level mismatch for rgb(%0d,%0d,%0d): expected %0d, actual %0d",
                   exp_hsv.red, exp_hsv.green, exp_hsv.blue, exp_hsv.val_level,
                   val_level);
            mismatches++;
         end
      endfunction

      function int pending();
         return pending_hsv.size();
      endfunction
   endclass

   // Drive every input to a known value from time zero.
   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             start     = 1'b0;
   logic [PIX_W-1:0] req_red   = '0;
   logic [PIX_W-1:0] req_green = '0;
   logic [PIX_W-1:0] req_blue  = '0;
   logic             busy;
   logic             rsp_valid;
   logic [HUE_W-1:0] rsp_hue_deg;
   logic [PIX_W-1:0] rsp_sat_level;
   logic [PIX_W-1:0] rsp_val_level;

   // Percentage of cycles in which the sender holds start low before a beat.
   int                 sender_idle_pct = 0;
   int                 quiet_cycles    = 0;
   hsv_scoreboard_type hsv_board       = new();

   rgb_to_hsv_pixel_convert_core dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_red       (req_red),
      .req_green     (req_green),
      .req_blue      (req_blue),
      .rsp_valid     (rsp_valid),
      .rsp_hue_deg   (rsp_hue_deg),
      .rsp_sat_level (rsp_sat_level),
      .rsp_val_level (rsp_val_level)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Offer one pixel beat: idle at random first, then hold start high until
   // the converter takes the beat at an edge with busy low.
   task automatic send_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                             input logic [PIX_W-1:0] b);
      while ($urandom_range(99) < sender_idle_pct) begin
         // Drop start and put junk on the data ports while idle.
         start     <= 1'b0;
         req_red   <= PIX_W'($urandom);
         req_green <= PIX_W'($urandom);
         req_blue  <= PIX_W'($urandom);
         @(posedge clock);
      end
      start     <= 1'b1;
      req_red   <= r;
      req_green <= g;
      req_blue  <= b;
      do @(posedge clock); while (busy !== 1'b0);
      hsv_board.note_pixel(r, g, b);
   endtask

   // Pick one channel value, leaning on the extremes and small values.
   function automatic logic [PIX_W-1:0] pick_channel();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         2:       return PIX_W'($urandom_range(3));
         3:       return PIX_W'(255 - $urandom_range(3));
         default: return PIX_W'($urandom);
      endcase
   endfunction

   // Send a random pixel: mostly independent channels, some with two channels
   // tied for the maximum or minimum, some gray.
   task automatic send_random_pixel();
      logic [PIX_W-1:0] r, g, b;
      int               shape;
      r     = pick_channel();
      g     = pick_channel();
      b     = pick_channel();
      shape = $urandom_range(99);
      if (shape < 8) begin
         g = r;
         b = r;
      end else if (shape < 16) begin
         g = r;
      end else if (shape < 24) begin
         b = r;
      end else if (shape < 32) begin
         b = g;
      end
      send_pixel(r, g, b);
   endtask

   // Check every result beat; the receiver cannot stall, so each strobe counts.
   always @(posedge clock) begin
      if (reset == 1'b0 && rsp_valid === 1'b1) begin
         hsv_board.check_result(rsp_hue_deg, rsp_sat_level, rsp_val_level);
      end
   end

   // Count cycles with no beat moving on either side and end a hung run.
   always @(posedge clock) begin
      if ((start && busy === 1'b0) || rsp_valid === 1'b1) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
         $display("** rgb_to_hsv_pixel_convert_core: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int idle_phases[4];
      idle_phases = '{0, 58, 35, 0};

      // Hold reset, then release it at an edge.
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed pixels, sent back to back.
      sender_idle_pct = 0;
      send_pixel(8'd0,   8'd0,   8'd0);     // black
      send_pixel(8'd255, 8'd255, 8'd255);   // white
      send_pixel(8'd128, 8'd128, 8'd128);   // mid gray
      send_pixel(8'd1,   8'd1,   8'd1);     // darkest gray
      send_pixel(8'd255, 8'd0,   8'd0);     // pure red
      send_pixel(8'd0,   8'd255, 8'd0);     // pure green
      send_pixel(8'd0,   8'd0,   8'd255);   // pure blue
      send_pixel(8'd255, 8'd255, 8'd0);     // red ties green, red wins
      send_pixel(8'd255, 8'd0,   8'd255);   // red ties blue, red wins
      send_pixel(8'd0,   8'd255, 8'd255);   // green ties blue, green wins
      send_pixel(8'd255, 8'd0,   8'd1);     // red sector sum of 360, wraps to 0
      send_pixel(8'd255, 8'd0,   8'd128);   // negative red-sector difference
      send_pixel(8'd255, 8'd0,   8'd254);   // red sector near magenta
      send_pixel(8'd255, 8'd128, 8'd0);     // positive red-sector difference
      send_pixel(8'd10,  8'd200, 8'd5);     // green sector, negative difference
      send_pixel(8'd3,   8'd7,   8'd250);   // blue sector, negative difference
      send_pixel(8'd250, 8'd7,   8'd251);   // blue sector, positive difference
      send_pixel(8'd1,   8'd0,   8'd0);     // smallest nonzero red
      send_pixel(8'd0,   8'd1,   8'd0);     // smallest nonzero green
      send_pixel(8'd0,   8'd0,   8'd1);     // smallest nonzero blue
      send_pixel(8'd255, 8'd254, 8'd254);   // delta of one at full scale
      send_pixel(8'd1,   8'd0,   8'd1);     // tie at the low end
      send_pixel(8'd254, 8'd255, 8'd0);     // green just above red
      send_pixel(8'd170, 8'd85,  8'd0);     // dark orange

      // Random pixels over phases of sender idling.
      foreach (idle_phases[p]) begin
         sender_idle_pct = idle_phases[p];
         repeat (RANDOM_PIXELS) send_random_pixel();
      end

      // Drop start, drain the pipeline, then allow its depth for stray beats.
      start <= 1'b0;
      while (hsv_board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (hsv_board.mismatches == 0) begin
         $display("** rgb_to_hsv_pixel_convert_core: PASSED **");
      end else begin
         $display("** rgb_to_hsv_pixel_convert_core: FAILED **");
      end
      $finish;
   end

endmodule

FILE: rgb_to_hsv_pixel_convert_core.f
+incdir+rtl
rtl/rhc_pkg.sv
rtl/rhc_prep.sv
rtl/rhc_div_stage.sv
rtl/rhc_hue_final.sv
rtl/rgb_to_hsv_pixel_convert_core.sv
rtl/rhc_checker.sv
verif/tb_rgb_to_hsv_pixel_convert_core.sv
